>>> rtl/lru_handle_cache_top_defines.svh
// Assertion macros used by the handle cache top level.
`ifndef LRU_HANDLE_CACHE_TOP_DEFINES_SVH
`define LRU_HANDLE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lhc_pkg.sv
// Shared constants and types of the handle cache.
package lhc_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int TAG_W   = 32;
    localparam int HND_W   = 16;
    localparam int STAMP_W = 64;
    localparam int ACT_W   = 2;
    localparam int ENTRY_W = TAG_W + HND_W + STAMP_W;

    localparam int IN_RAW_W   = TAG_W + HND_W;
    localparam int IN_W       = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = HND_W + HND_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam logic [ACT_W-1:0] ACT_TAKE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    typedef struct packed {
        logic tag_eq;
        logic stamp_lt;
    } cmp_res_t;

endpackage

>>> rtl/lhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lhc_cmp.sv
// Shared compare unit: tag match and stamp ordering for the slot under scan.
module lhc_cmp (
    input  logic [lhc_pkg::TAG_W-1:0]   key,
    input  logic [lhc_pkg::TAG_W-1:0]   tag,
    input  logic [lhc_pkg::STAMP_W-1:0] stamp,
    input  logic [lhc_pkg::STAMP_W-1:0] min_stamp,
    output lhc_pkg::cmp_res_t           res
);
    import lhc_pkg::*;

    always_comb
    begin
        res.tag_eq   = (tag == key);
        res.stamp_lt = (stamp < min_stamp);
    end

endmodule

>>> rtl/lru_handle_cache_top.sv
// Top level of the LRU handle cache: slot scan sequencer, slot RAM and output register.
//
// Input channel (s_*): one beat carries action, key and handle. Action take
// looks the key up and frees its slot on a hit; put stores key and handle in
// the lowest empty slot, or evicts the least recently stamped entry when the
// cache is full; flush releases every stored handle and empties the cache.
// Output channel (m_*): take and put give one beat with m_tlast high. Flush
// gives one beat per stored handle in slot order, m_tlast on the final one,
// or a single all-zero beat when the cache is empty.
// Sequencing: one item is worked on at a time and s_tready is high only
// while the sequencer is idle. Slot entries sit in one RAM with a registered
// read port, and the scan reads one slot per cycle, pausing in a flush while
// the output stalls, through a single shared compare unit.
// Reset: all slots are marked empty and the use clock returns to zero at
// once; no clearing pass is needed. When the receiver stalls, the output
// register holds its beat and the flush scan pauses until it drains.
`include "lru_handle_cache_top_defines.svh"

module lru_handle_cache_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] key, [47:32] handle
    input  logic [lhc_pkg::IN_W-1:0]       s_tdata,
    // [1:0] action
    input  logic [lhc_pkg::ACT_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] handle_out, [31:16] released_handle
    output logic [lhc_pkg::OUT_W-1:0]      m_tdata,
    // [0] hit, [1] released
    output logic [lhc_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import lhc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    function automatic logic [OUT_W-1:0] pack_out(
        input logic [HND_W-1:0] hout,
        input logic [HND_W-1:0] rhnd
    );
        pack_out = OUT_W'({rhnd, hout});
    endfunction

    // Sequencer state.
    logic [1:0]         state_reg,    state_next;
    logic [ACT_W-1:0]   act_reg,      act_next;
    logic [TAG_W-1:0]   key_reg,      key_next;
    logic [HND_W-1:0]   hnd_reg,      hnd_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic [SLOTS-1:0]   valid_reg,    valid_next;
    logic [STAMP_W-1:0] clock_reg,    clock_next;

    // Oldest-entry tracking during a put scan.
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic [IDX_W-1:0]   min_idx_reg,   min_idx_next;
    logic [HND_W-1:0]   min_hnd_reg,   min_hnd_next;
    logic [IDX_W-1:0]   target_reg,    target_next;

    // Result fields of a take, put or empty flush.
    logic               res_hit_reg,  res_hit_next;
    logic [HND_W-1:0]   res_hout_reg, res_hout_next;
    logic               res_rel_reg,  res_rel_next;
    logic [HND_W-1:0]   res_rhnd_reg, res_rhnd_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg,  out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg,  out_user_next;
    logic                  out_last_reg,  out_last_next;

    logic                  out_free;
    logic                  out_load;
    logic [OUT_W-1:0]      out_load_data;
    logic [OUT_USER_W-1:0] out_load_user;
    logic                  out_load_last;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    logic [TAG_W-1:0]   rd_tag;
    logic [HND_W-1:0]   rd_hnd;
    logic [STAMP_W-1:0] rd_stamp;
    cmp_res_t           cmp;

    logic               cur_valid;
    logic               at_last;
    logic               sel_min;
    logic [SLOTS-1:0]   cur_mask;
    logic [IDX_W-1:0]   next_idx;

    lhc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (target_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_tag   = rd_data[TAG_W-1:0];
    assign rd_hnd   = rd_data[TAG_W+HND_W-1:TAG_W];
    assign rd_stamp = rd_data[ENTRY_W-1:TAG_W+HND_W];

    lhc_cmp u_cmp (
        .key       (key_reg),
        .tag       (rd_tag),
        .stamp     (rd_stamp),
        .min_stamp (min_stamp_reg),
        .res       (cmp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign out_free  = !out_valid_reg || m_tready;
    assign cur_valid = valid_reg[eval_idx_reg];
    assign at_last   = (eval_idx_reg == LAST_IDX);
    assign sel_min   = (eval_idx_reg == '0) || cmp.stamp_lt;
    assign cur_mask  = SLOTS'(1) << eval_idx_reg;
    assign next_idx  = eval_idx_reg + IDX_W'(1);
    assign wr_data   = {clock_reg + STAMP_W'(1), hnd_reg, key_reg};

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        hnd_next       = hnd_reg;
        eval_idx_next  = eval_idx_reg;
        valid_next     = valid_reg;
        clock_next     = clock_reg;
        min_stamp_next = min_stamp_reg;
        min_idx_next   = min_idx_reg;
        min_hnd_next   = min_hnd_reg;
        target_next    = target_reg;
        res_hit_next   = res_hit_reg;
        res_hout_next  = res_hout_reg;
        res_rel_next   = res_rel_reg;
        res_rhnd_next  = res_rhnd_reg;
        rd_en          = 1'b0;
        rd_addr        = eval_idx_reg;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_load_data  = '0;
        out_load_user  = '0;
        out_load_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next      = s_tuser;
                    key_next      = s_tdata[TAG_W-1:0];
                    hnd_next      = s_tdata[TAG_W+HND_W-1:TAG_W];
                    eval_idx_next = '0;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    res_hit_next  = 1'b0;
                    res_hout_next = '0;
                    res_rel_next  = 1'b0;
                    res_rhnd_next = '0;
                    case (s_tuser)
                        ACT_TAKE, ACT_PUT:
                        begin
                            state_next = ST_SCAN;
                        end
                        ACT_FLUSH:
                        begin
                            // An empty cache answers a flush with a single zero beat.
                            state_next = (valid_reg == '0) ? ST_RESULT : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                case (act_reg)
                    ACT_TAKE:
                    begin
                        if (cur_valid && cmp.tag_eq)
                        begin
                            res_hit_next  = 1'b1;
                            res_hout_next = rd_hnd;
                            valid_next    = valid_reg & ~cur_mask;
                            state_next    = ST_RESULT;
                        end
                        else if (at_last)
                        begin
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = next_idx;
                            eval_idx_next = next_idx;
                        end
                    end

                    ACT_PUT:
                    begin
                        if (!cur_valid)
                        begin
                            target_next = eval_idx_reg;
                            state_next  = ST_WRITE;
                        end
                        else
                        begin
                            if (sel_min)
                            begin
                                min_stamp_next = rd_stamp;
                                min_idx_next   = eval_idx_reg;
                                min_hnd_next   = rd_hnd;
                            end
                            if (at_last)
                            begin
                                // Cache full: evict the oldest stamp, first on ties.
                                target_next   = sel_min ? eval_idx_reg : min_idx_reg;
                                res_rel_next  = 1'b1;
                                res_rhnd_next = sel_min ? rd_hnd : min_hnd_reg;
                                state_next    = ST_WRITE;
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = next_idx;
                                eval_idx_next = next_idx;
                            end
                        end
                    end

                    ACT_FLUSH:
                    begin
                        if (cur_valid)
                        begin
                            if (out_free)
                            begin
                                out_load      = 1'b1;
                                out_load_data = pack_out('0, rd_hnd);
                                // Released flag set, hit flag clear.
                                out_load_user = {1'b1, 1'b0};
                                out_load_last = ((valid_reg & ~cur_mask) == '0);
                                valid_next    = valid_reg & ~cur_mask;
                                if (out_load_last || at_last)
                                begin
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    rd_en         = 1'b1;
                                    rd_addr       = next_idx;
                                    eval_idx_next = next_idx;
                                end
                            end
                        end
                        else if (at_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = next_idx;
                            eval_idx_next = next_idx;
                        end
                    end

                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_WRITE:
            begin
                wr_en                  = 1'b1;
                clock_next             = clock_reg + STAMP_W'(1);
                valid_next[target_reg] = 1'b1;
                state_next             = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = pack_out(res_hout_reg, res_rhnd_reg);
                    out_load_user = {res_rel_reg, res_hit_reg};
                    out_load_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_load_data;
            out_user_next  = out_load_user;
            out_last_next  = out_load_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        hnd_reg       <= hnd_next;
        eval_idx_reg  <= eval_idx_next;
        min_stamp_reg <= min_stamp_next;
        min_idx_reg   <= min_idx_next;
        min_hnd_reg   <= min_hnd_next;
        target_reg    <= target_next;
        res_hit_reg   <= res_hit_next;
        res_hout_reg  <= res_hout_next;
        res_rel_reg   <= res_rel_next;
        res_rhnd_reg  <= res_rhnd_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    // Only flush releases may leave a beat that is not the final one of its item.
    `LHC_ASSERT_NOW(a_mid_beat_is_release, m_tvalid && !m_tlast, m_tuser[1],
        "non-final beat without a released handle")
    // A take hit never releases a handle.
    `LHC_ASSERT_NOW(a_hit_not_release, m_tvalid && m_tuser[0], !m_tuser[1] && m_tlast,
        "take hit beat marks a release")
    // A put write leaves its target slot occupied.
    `LHC_ASSERT_NEXT(a_put_fills_slot, state_reg == ST_WRITE,
        valid_reg[$past(target_reg)], "put target slot not valid after write")

endmodule
